/* rtl/tbw_pkg.sv */
// Package: widths and defaults shared by the barycentric weights core.
`default_nettype none

package tbw_pkg;

    // default coordinate and fraction widths
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // one weight field and the packed result word
    localparam int W_BITS   = 32;
    localparam int OUT_BITS = 3 * W_BITS;

    typedef logic signed [W_BITS-1:0] weight_t;

    // saturation limits
    localparam weight_t W_MAX = {1'b0, {(W_BITS-1){1'b1}}};
    localparam weight_t W_MIN = {1'b1, {(W_BITS-1){1'b0}}};

endpackage : tbw_pkg

`default_nettype wire

/* rtl/triangle_barycentric_weights_core.sv */
// Top level: pipelined barycentric weights of a point against a triangle.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: px, py, ax, ay, bx, by, cx, cy
//  m_      | out | m_tvalid/m_tready  | m_tdata: alpha, beta, gamma; m_tuser: degenerate
//
// One transfer in per cycle unless a waiting result holds the pipeline; stages:
// differences, products, cross sums, operand setup, one restoring-division
// stage per quotient bit for alpha and beta side by side, saturation, then
// gamma into the output register.
// aresetn (synchronous) clears only the valid bits.
// A waiting result freezes every stage behind it; the entry stage still
// takes a transfer while it is empty.
`default_nettype none

module triangle_barycentric_weights_core #(
    parameter int COORD_BITS = tbw_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tbw_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // px, py, ax, ay, bx, by, cx, cy, COORD_BITS each, zero pad on top
    input  wire logic [((8*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // weight_alpha, weight_beta, weight_gamma, 32 bits each
    output logic [tbw_pkg::OUT_BITS-1:0]               m_tdata,
    // degenerate
    output logic                                       m_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready
);
    import tbw_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;              // coordinate difference
    localparam int PW = 2 * CB + 2;          // product
    localparam int AW = 2 * CB + 3;          // cross product sum
    localparam int MW = AW - 1;              // magnitude of a cross product
    localparam int NW = MW + FRAC_BITS;      // dividend and quotient
    localparam int QX = (NW > W_BITS + 1) ? NW : W_BITS + 1;
    localparam int GW = W_BITS + 2;          // gamma before clamping

    // pipeline advance: output empty or being taken
    logic adv;
    assign adv = !m_tvalid || m_tready;

    // ---------------- stage 1: coordinate differences ----------------
    logic signed [CB-1:0] px, py, ax, ay, bx, by, cx, cy;
    assign px = s_tdata[0*CB +: CB];
    assign py = s_tdata[1*CB +: CB];
    assign ax = s_tdata[2*CB +: CB];
    assign ay = s_tdata[3*CB +: CB];
    assign bx = s_tdata[4*CB +: CB];
    assign by = s_tdata[5*CB +: CB];
    assign cx = s_tdata[6*CB +: CB];
    assign cy = s_tdata[7*CB +: CB];

    logic                 v1_reg;
    logic signed [DW-1:0] abx_reg, aby_reg, acx_reg, acy_reg, apx_reg, apy_reg;
    logic signed [DW-1:0] bcx_reg, bcy_reg, bpx_reg, bpy_reg;
    logic                 en1;

    assign en1      = !v1_reg || adv;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            abx_reg <= DW'(bx) - DW'(ax);
            aby_reg <= DW'(by) - DW'(ay);
            acx_reg <= DW'(cx) - DW'(ax);
            acy_reg <= DW'(cy) - DW'(ay);
            apx_reg <= DW'(px) - DW'(ax);
            apy_reg <= DW'(py) - DW'(ay);
            bcx_reg <= DW'(cx) - DW'(bx);
            bcy_reg <= DW'(cy) - DW'(by);
            bpx_reg <= DW'(px) - DW'(bx);
            bpy_reg <= DW'(py) - DW'(by);
        end
    end

    // ---------------- stage 2: products ----------------
    logic                 v2_reg;
    logic signed [PW-1:0] p_area0_reg, p_area1_reg;
    logic signed [PW-1:0] p_bcp0_reg, p_bcp1_reg;
    logic signed [PW-1:0] p_acp0_reg, p_acp1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_area0_reg <= abx_reg * acy_reg;
            p_area1_reg <= aby_reg * acx_reg;
            p_bcp0_reg  <= bcx_reg * bpy_reg;
            p_bcp1_reg  <= bpx_reg * bcy_reg;
            p_acp0_reg  <= apx_reg * acy_reg;
            p_acp1_reg  <= acx_reg * apy_reg;
        end
    end

    // ---------------- stage 3: cross product sums ----------------
    logic                 v3_reg;
    logic signed [AW-1:0] area_reg, bcp_reg, acp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            area_reg <= AW'(p_area0_reg) - AW'(p_area1_reg);
            bcp_reg  <= AW'(p_bcp0_reg) - AW'(p_bcp1_reg);
            acp_reg  <= AW'(p_acp0_reg) - AW'(p_acp1_reg);
        end
    end

    // ---------------- stage 4: divider operand setup ----------------
    // Index 0 of the division arrays is this stage; index k holds the
    // state after k quotient bits. Lane 0 is alpha, lane 1 is beta.
    logic [AW-1:0] area_abs, bcp_abs, acp_abs;
    assign area_abs = area_reg[AW-1] ? AW'(-area_reg) : AW'(area_reg);
    assign bcp_abs  = bcp_reg[AW-1]  ? AW'(-bcp_reg)  : AW'(bcp_reg);
    assign acp_abs  = acp_reg[AW-1]  ? AW'(-acp_reg)  : AW'(acp_reg);

    logic          dv_reg   [NW+1];
    logic          zero_reg [NW+1];
    logic [MW-1:0] den_reg  [NW+1];
    logic [1:0]    neg_reg  [NW+1];
    logic [MW-1:0] rem_reg  [NW+1][2];
    logic [NW-1:0] nq_reg   [NW+1][2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zero_reg[0]   <= (area_reg == '0);
            den_reg[0]    <= area_abs[MW-1:0];
            neg_reg[0][0] <= bcp_reg[AW-1] ^ area_reg[AW-1];
            neg_reg[0][1] <= acp_reg[AW-1] ^ area_reg[AW-1];
            rem_reg[0][0] <= '0;
            rem_reg[0][1] <= '0;
            nq_reg[0][0]  <= {bcp_abs[MW-1:0], {FRAC_BITS{1'b0}}};
            nq_reg[0][1]  <= {acp_abs[MW-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    // ---------------- restoring division, one bit per stage ----------------
    // nq holds the unused dividend bits on top and the quotient bits below.
    for (genvar k = 1; k <= NW; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k] <= 1'b0;
            end else if (adv) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                zero_reg[k] <= zero_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [MW:0]   trial;
            logic [MW:0]   diff;
            logic          ge;
            logic [MW-1:0] rem_next;

            assign trial    = {rem_reg[k-1][l], nq_reg[k-1][l][NW-1]};
            assign diff     = trial - {1'b0, den_reg[k-1]};
            assign ge       = (trial >= {1'b0, den_reg[k-1]});
            assign rem_next = ge ? diff[MW-1:0] : trial[MW-1:0];

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[k][l] <= rem_next;
                    nq_reg[k][l]  <= {nq_reg[k-1][l][NW-2:0], ge};
                end
            end
        end
    end

    // ---------------- sign and saturation of alpha and beta ----------------
    logic    sv_reg;
    logic    szero_reg;
    weight_t sat_reg [2];
    weight_t sat_next [2];

    always_comb begin
        logic [QX-1:0] qx;
        for (int l = 0; l < 2; l++) begin
            qx = QX'(nq_reg[NW][l]);
            if (neg_reg[NW][l]) begin
                if (qx > (QX'(1) << (W_BITS - 1))) begin
                    sat_next[l] = W_MIN;
                end else begin
                    sat_next[l] = weight_t'(W_BITS'(0) - qx[W_BITS-1:0]);
                end
            end else begin
                if (qx > QX'(W_MAX)) begin
                    sat_next[l] = W_MAX;
                end else begin
                    sat_next[l] = weight_t'(qx[W_BITS-1:0]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= 1'b0;
        end else if (adv) begin
            sv_reg <= dv_reg[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            szero_reg  <= zero_reg[NW];
            sat_reg[0] <= sat_next[0];
            sat_reg[1] <= sat_next[1];
        end
    end

    // ---------------- gamma and output register ----------------
    logic signed [GW-1:0] gamma_wide;
    weight_t              gamma_sat;

    assign gamma_wide = (GW'(1) << FRAC_BITS) - GW'(sat_reg[0]) - GW'(sat_reg[1]);

    always_comb begin
        if (gamma_wide > GW'(W_MAX)) begin
            gamma_sat = W_MAX;
        end else if (gamma_wide < GW'(W_MIN)) begin
            gamma_sat = W_MIN;
        end else begin
            gamma_sat = weight_t'(gamma_wide[W_BITS-1:0]);
        end
    end

    logic                m_tvalid_reg;
    logic [OUT_BITS-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= sv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tuser_reg <= szero_reg;
            if (szero_reg) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {gamma_sat, sat_reg[1], sat_reg[0]};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result with nonzero weights");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    a_div_to_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && dv_reg[NW] |=> sv_reg)
        else $error("item lost between divider and saturation");

    a_sat_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && sv_reg |=> m_tvalid)
        else $error("item lost before output register");

endmodule : triangle_barycentric_weights_core

`default_nettype wire
